// File: rtl/npd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_pkg
// Shared constants, tables and types of the near point distance filter.
// ----------------------------------------------------------------------------
package npd_pkg;

   // coordinate and fixed-point formats
   localparam int COORD_BITS    = 29;
   localparam int COS_FRAC_BITS = 17;
   localparam int MAG_W         = COORD_BITS + 1;
   localparam int SCALE_W       = 23;
   localparam int MUL_W         = 29;
   localparam int COS_W         = COS_FRAC_BITS + 1;

   // metres per coordinate unit, Q0.24
   localparam logic [SCALE_W-1:0] SCALE_MODE0 = 23'd5187258;
   localparam logic [SCALE_W-1:0] SCALE_MODE1 = 23'd1867413;

   // binary-angle multipliers, 2^56 per turn of coordinate units
   localparam logic [MUL_W-1:0] ANGLE_MUL_MODE0 = 29'd277999977;
   localparam logic [MUL_W-1:0] ANGLE_MUL_MODE1 = 29'd100079992;

   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

   localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;

   // Horner steps, n = 7 down to 1; divisor (2n)(2n-1) done as an exact
   // reciprocal multiply for 32-bit dividends
   localparam int HORNER_STEPS = 7;
   localparam logic [32:0] HORNER_RECIP [HORNER_STEPS] = '{
      33'(((65'd1 << 40) + 65'd181) / 65'd182),
      33'(((65'd1 << 40) + 65'd131) / 65'd132),
      33'(((65'd1 << 39) + 65'd89)  / 65'd90),
      33'(((65'd1 << 38) + 65'd55)  / 65'd56),
      33'(((65'd1 << 37) + 65'd29)  / 65'd30),
      33'(((65'd1 << 36) + 65'd11)  / 65'd12),
      33'(((65'd1 << 33) + 65'd1)   / 65'd2)
   };
   localparam logic [6:0] HORNER_SHIFT [HORNER_STEPS] = '{
      7'd40, 7'd40, 7'd39, 7'd38, 7'd37, 7'd36, 7'd33
   };

   localparam int SQRT_STEPS = 32;

   // accept edge to result strobe
   localparam int LATENCY = 4 + 2 * HORNER_STEPS + 5 + SQRT_STEPS + 1;

   // register indexes
   typedef enum logic [1:0] {
      CSR_MAX_DISTANCE   = 2'd0,
      CSR_BOX_HALF_WIDTH = 2'd1,
      CSR_UNIT_MODE      = 2'd2
   } csr_index_type;

   // data handed along the cosine chain
   typedef struct packed {
      logic [31:0] x2;
      logic [30:0] t;
   } hcell_type;

   // data handed along the square root chain
   typedef struct packed {
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
   } scell_type;

endpackage

// File: rtl/npd_horner_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_horner_cell
// One Horner step of the cosine series: t = 1 - floor(x2 * t / 2^30) / d.
// ----------------------------------------------------------------------------
module npd_horner_cell (
   input  logic              clock,
   input  npd_pkg::hcell_type cell_in,
   input  logic [32:0]       recip,
   input  logic [6:0]        shift,
   output npd_pkg::hcell_type cell_out
);
   import npd_pkg::*;

   logic [62:0] prod;
   logic [31:0] p_in,  p_ff;
   logic [31:0] x2a_ff, x2b_ff;
   logic [64:0] qm_in, qm_ff;
   logic [64:0] q_full;
   logic [31:0] q;

   // multiply by the running term
   assign prod = 63'(cell_in.x2) * 63'(cell_in.t);
   assign p_in = prod[61:30];

   // divide by the step constant
   assign qm_in = 65'(p_ff) * 65'(recip);

   // advance two register stages
   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      x2a_ff <= cell_in.x2;
      qm_ff  <= qm_in;
      x2b_ff <= x2a_ff;
   end

   // subtract from one, clamp at zero
   assign q_full = qm_ff >> shift;
   assign q      = q_full[31:0];
   always_comb begin
      cell_out.x2 = x2b_ff;
      if (q > 32'(ONE_Q30)) begin
         cell_out.t = '0;
      end else begin
         cell_out.t = ONE_Q30 - q[30:0];
      end
   end

endmodule

// File: rtl/npd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_sqrt_cell
// One restoring square root step: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module npd_sqrt_cell (
   input  logic              clock,
   input  npd_pkg::scell_type cell_in,
   output npd_pkg::scell_type cell_out
);
   import npd_pkg::*;

   logic [35:0] trial_rem;
   logic [35:0] trial_sub;
   scell_type   cell_in_d, cell_ff;

   // bring down two bits, try the next root bit
   assign trial_rem = {cell_in.rem, cell_in.rad[63:62]};
   assign trial_sub = {2'b00, cell_in.root, 2'b01};

   always_comb begin
      cell_in_d.rad = {cell_in.rad[61:0], 2'b00};
      if (trial_rem >= trial_sub) begin
         cell_in_d.rem  = 34'(trial_rem - trial_sub);
         cell_in_d.root = {cell_in.root[30:0], 1'b1};
      end else begin
         cell_in_d.rem  = trial_rem[33:0];
         cell_in_d.root = {cell_in.root[30:0], 1'b0};
      end
   end

   // hand to the next cell
   always_ff @(posedge clock) begin
      cell_ff <= cell_in_d;
   end

   assign cell_out = cell_ff;

endmodule

// File: rtl/near_point_distance_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_point_distance_filter_unit
// Box prefilter and equirectangular distance between two points, pipelined.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   req_ref_x/y, req_cand_x/y          start & !busy
//  response  rsp_near/raw_distance, rsp_box_pass rsp_valid strobe, 1 cycle
//  config    csr_index, csr_data                csr_valid & csr_ready
//
//  One item enters every cycle; busy stays low. Each result passes
//  the seven-cell cosine chain (two stages a cell) and the 32-cell
//  square root chain before it reaches the output registers.
//  Reset clears the valid pipeline and loads register defaults.
//  The receiver cannot stall; results stream out in accept order.
// ----------------------------------------------------------------------------
module near_point_distance_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [npd_pkg::COORD_BITS-1:0] req_ref_x,
   input  logic signed [npd_pkg::COORD_BITS-1:0] req_ref_y,
   input  logic signed [npd_pkg::COORD_BITS-1:0] req_cand_x,
   input  logic signed [npd_pkg::COORD_BITS-1:0] req_cand_y,
   output logic                                 rsp_valid,
   output logic [23:0]                          rsp_near_distance,
   output logic [23:0]                          rsp_raw_distance,
   output logic                                 rsp_box_pass,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [1:0]                           csr_index,
   input  logic [27:0]                          csr_data
);
   import npd_pkg::*;

   localparam int NORTH_W  = COORD_BITS + 9;
   localparam int ANG_W    = MAG_W + MUL_W + 1;
   localparam int LONCP_W  = MAG_W + COS_W;
   localparam int LONC_W   = LONCP_W - (COS_FRAC_BITS - 8);
   localparam int LO_W     = 20;
   localparam int HI_W     = LONC_W - LO_W;
   localparam int EASTF_W  = LONC_W + SCALE_W;
   localparam int EAST_W   = EASTF_W - 24;
   localparam int HSTAGES  = 2 * HORNER_STEPS;

   typedef struct packed {
      logic [MAG_W-1:0]   magx;
      logic [NORTH_W-1:0] north;
      logic               pass;
   } hside_type;

   typedef struct packed {
      logic sat;
      logic pass;
   } sside_type;

   // configuration registers
   logic [23:0] max_distance_ff;
   logic [27:0] box_half_width_ff;
   logic        unit_mode_ff;

   logic accept;
   logic [LATENCY-1:0] valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff   <= 24'd1000;
         box_half_width_ff <= 28'd4096;
         unit_mode_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_DISTANCE:   max_distance_ff   <= csr_data[23:0];
            CSR_BOX_HALF_WIDTH: box_half_width_ff <= csr_data;
            CSR_UNIT_MODE:      unit_mode_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // advance the valid line
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LATENCY-2:0], accept};
      end
   end

   logic [SCALE_W-1:0] scale;
   logic [MUL_W-1:0]   ang_mul;
   assign scale   = unit_mode_ff ? SCALE_MODE1 : SCALE_MODE0;
   assign ang_mul = unit_mode_ff ? ANGLE_MUL_MODE1 : ANGLE_MUL_MODE0;

   // stage 1: differences, magnitudes, box test
   logic signed [MAG_W-1:0] dx, dy, lat_sum;
   logic [MAG_W-1:0] magx_in, magy_in;
   logic pass_in;
   logic [MAG_W-1:0] magx1_ff, magy1_ff;
   logic signed [MAG_W-1:0] lat_sum1_ff;
   logic pass1_ff;

   assign dx      = MAG_W'(req_ref_x) - MAG_W'(req_cand_x);
   assign dy      = MAG_W'(req_ref_y) - MAG_W'(req_cand_y);
   assign lat_sum = MAG_W'(req_ref_y) + MAG_W'(req_cand_y);
   assign magx_in = dx[MAG_W-1] ? $unsigned(-dx) : $unsigned(dx);
   assign magy_in = dy[MAG_W-1] ? $unsigned(-dy) : $unsigned(dy);
   assign pass_in = (33'(magx_in) < 33'(box_half_width_ff)) &&
                    (33'(magy_in) < 33'(box_half_width_ff));

   always_ff @(posedge clock) begin
      magx1_ff    <= magx_in;
      magy1_ff    <= magy_in;
      lat_sum1_ff <= lat_sum;
      pass1_ff    <= pass_in;
   end

   // stage 2: angle product and north offset
   logic signed [ANG_W-1:0] ang_prod;
   logic signed [55:0] ang_in, ang2_ff;
   logic [NORTH_W+15:0] north_prod;
   logic [NORTH_W-1:0] north2_ff;
   logic [MAG_W-1:0] magx2_ff;
   logic pass2_ff;

   assign ang_prod   = lat_sum1_ff * $signed({1'b0, ang_mul});
   assign ang_in     = 56'(ang_prod);
   assign north_prod = (NORTH_W+16)'(magy1_ff) * (NORTH_W+16)'(scale);

   always_ff @(posedge clock) begin
      ang2_ff   <= ang_in;
      north2_ff <= north_prod[NORTH_W+15:16];
      magx2_ff  <= magx1_ff;
      pass2_ff  <= pass1_ff;
   end

   // stage 3: fold the angle to a quarter turn, scale to radians
   logic [31:0] ang_a, ang_neg, ang_fold;
   logic [61:0] x_prod, x3_ff;
   hside_type side3_ff;

   assign ang_a   = ang2_ff[55:24];
   assign ang_neg = ang_a[31] ? (32'd0 - ang_a) : ang_a;
   assign ang_fold = (ang_neg > 32'h4000_0000) ? (32'h8000_0000 - ang_neg) : ang_neg;
   assign x_prod  = 62'(ang_fold[30:0]) * 62'(HALF_PI_Q30);

   always_ff @(posedge clock) begin
      x3_ff          <= x_prod;
      side3_ff.magx  <= magx2_ff;
      side3_ff.north <= north2_ff;
      side3_ff.pass  <= pass2_ff;
   end

   // stage 4: square the angle
   logic [30:0] x_val;
   logic [61:0] x2_prod, x2_4_ff;
   hside_type side4_ff;

   assign x_val   = x3_ff[60:30];
   assign x2_prod = 62'(x_val) * 62'(x_val);

   always_ff @(posedge clock) begin
      x2_4_ff  <= x2_prod;
      side4_ff <= side3_ff;
   end

   // cosine chain
   hcell_type hlink [HORNER_STEPS+1];
   assign hlink[0].x2 = x2_4_ff[61:30];
   assign hlink[0].t  = ONE_Q30;

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
      npd_horner_cell u_cell (
         .clock    (clock),
         .cell_in  (hlink[i]),
         .recip    (HORNER_RECIP[i]),
         .shift    (HORNER_SHIFT[i]),
         .cell_out (hlink[i+1])
      );
   end

   // hold side data along the cosine chain
   hside_type hside_ff [HSTAGES];
   always_ff @(posedge clock) begin
      hside_ff[0] <= side4_ff;
      for (int k = 1; k < HSTAGES; k++) begin
         hside_ff[k] <= hside_ff[k-1];
      end
   end

   // stage 5: round the cosine, scale the longitude difference
   logic [30:0] cos_sum;
   logic [COS_W-1:0] cos_val;
   logic [LONCP_W-1:0] lonc_prod, lonc5_ff;
   hside_type side5_ff;

   assign cos_sum   = hlink[HORNER_STEPS].t + (31'd1 << (29 - COS_FRAC_BITS));
   assign cos_val   = cos_sum[30:30-COS_FRAC_BITS];
   assign lonc_prod = LONCP_W'(hside_ff[HSTAGES-1].magx) * LONCP_W'(cos_val);

   always_ff @(posedge clock) begin
      lonc5_ff <= lonc_prod;
      side5_ff <= hside_ff[HSTAGES-1];
   end

   // stage 6: east offset as two partial products
   logic [LONC_W-1:0] lonc;
   logic [LO_W+SCALE_W-1:0] elo_prod, elo6_ff;
   logic [HI_W+SCALE_W-1:0] ehi_prod, ehi6_ff;
   hside_type side6_ff;

   assign lonc     = lonc5_ff[LONCP_W-1:COS_FRAC_BITS-8];
   assign elo_prod = (LO_W+SCALE_W)'(lonc[LO_W-1:0]) * (LO_W+SCALE_W)'(scale);
   assign ehi_prod = (HI_W+SCALE_W)'(lonc[LONC_W-1:LO_W]) * (HI_W+SCALE_W)'(scale);

   always_ff @(posedge clock) begin
      elo6_ff  <= elo_prod;
      ehi6_ff  <= ehi_prod;
      side6_ff <= side5_ff;
   end

   // stage 7: combine partials, test offsets for saturation
   logic [EASTF_W-1:0] east_full;
   logic [EAST_W-1:0] east;
   logic [31:0] east7_ff, north7_ff;
   logic sat7_ff, pass7_ff;

   assign east_full = (EASTF_W'(ehi6_ff) << LO_W) + EASTF_W'(elo6_ff);
   assign east      = east_full[EASTF_W-1:24];

   always_ff @(posedge clock) begin
      east7_ff  <= east[31:0];
      north7_ff <= side6_ff.north[31:0];
      sat7_ff   <= (|east[EAST_W-1:32]) | (|side6_ff.north[NORTH_W-1:32]);
      pass7_ff  <= side6_ff.pass;
   end

   // stage 8: squares
   logic [63:0] n2_8_ff, e2_8_ff;
   logic sat8_ff, pass8_ff;

   always_ff @(posedge clock) begin
      n2_8_ff  <= 64'(north7_ff) * 64'(north7_ff);
      e2_8_ff  <= 64'(east7_ff) * 64'(east7_ff);
      sat8_ff  <= sat7_ff;
      pass8_ff <= pass7_ff;
   end

   // stage 9: sum of squares, overflow saturates
   logic [64:0] sq_sum;
   logic [63:0] sum9_ff;
   sside_type side9_ff;

   assign sq_sum = 65'(n2_8_ff) + 65'(e2_8_ff);

   always_ff @(posedge clock) begin
      sum9_ff       <= sq_sum[63:0];
      side9_ff.sat  <= sat8_ff | sq_sum[64];
      side9_ff.pass <= pass8_ff;
   end

   // square root chain
   scell_type slink [SQRT_STEPS+1];
   assign slink[0].rad  = sum9_ff;
   assign slink[0].rem  = '0;
   assign slink[0].root = '0;

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      npd_sqrt_cell u_cell (
         .clock    (clock),
         .cell_in  (slink[j]),
         .cell_out (slink[j+1])
      );
   end

   // hold flags along the square root chain
   sside_type sside_ff [SQRT_STEPS];
   always_ff @(posedge clock) begin
      sside_ff[0] <= side9_ff;
      for (int k = 1; k < SQRT_STEPS; k++) begin
         sside_ff[k] <= sside_ff[k-1];
      end
   end

   // final stage: metres, near decision
   logic [23:0] dist_m, dist_min1, near_in;
   logic [23:0] near_ff, raw_ff;
   logic pass_ff;

   assign dist_m    = sside_ff[SQRT_STEPS-1].sat ? DIST_MAX :
                      slink[SQRT_STEPS].root[31:8];
   assign dist_min1 = (dist_m == 24'd0) ? 24'd1 : dist_m;
   assign near_in   = (sside_ff[SQRT_STEPS-1].pass && (dist_min1 < max_distance_ff)) ?
                      dist_min1 : 24'd0;

   always_ff @(posedge clock) begin
      near_ff <= near_in;
      raw_ff  <= dist_m;
      pass_ff <= sside_ff[SQRT_STEPS-1].pass;
   end

   assign rsp_valid         = valid_ff[LATENCY-1];
   assign rsp_near_distance = near_ff;
   assign rsp_raw_distance  = raw_ff;
   assign rsp_box_pass      = pass_ff;

endmodule

// File: rtl/npd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_checker
// Port-level checks of the near point distance filter, bound to the top.
// ----------------------------------------------------------------------------
module npd_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [23:0] rsp_near_distance,
   input logic [23:0] rsp_raw_distance,
   input logic        rsp_box_pass
);
   import npd_pkg::*;

   // every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after accepted item");

   // a near result needs the box to pass
   a_near_box: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_near_distance != 24'd0) |-> rsp_box_pass)
      else $error("near result without box pass");

   // a near result is the raw distance, zero raised to one
   a_near_raw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_near_distance != 24'd0) |->
      (rsp_near_distance == rsp_raw_distance ||
       (rsp_raw_distance == 24'd0 && rsp_near_distance == 24'd1)))
      else $error("near result differs from raw distance");

   // results only follow accepted items
   a_no_stray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without accepted item");

endmodule

bind near_point_distance_filter_unit npd_checker u_npd_checker (.*);

// File: tb/tb_near_point_distance_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_near_point_distance_filter_unit
// Self-checking bench for the near point distance filter. Point pairs are
// sent with random gaps; a bit-exact model of the box prefilter, the
// fixed-point cosine and the integer root predicts each result, and every
// strobed result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_near_point_distance_filter_unit;
   import npd_pkg::*;

   localparam logic [1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int         DRAIN_CYCLES    = LATENCY + 8;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct {
      logic [23:0] near_dist;
      logic [23:0] raw_dist;
      logic        in_box;
   } dist_result_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   coord_type req_ref_x, req_ref_y, req_cand_x, req_cand_y;
   logic rsp_valid;
   logic [23:0] rsp_near_distance, rsp_raw_distance;
   logic rsp_box_pass;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [27:0] csr_data;

   // shadow copy of the block's registers
   logic [23:0] lim_distance;
   logic [27:0] lim_box;
   logic        metric_micro;

   dist_result_type pending_q[$];
   int errors = 0, n_checked = 0, n_near = 0, n_box_fail = 0, n_sat = 0;

   near_point_distance_filter_unit u_dut (
      .clock, .reset, .start, .busy,
      .req_ref_x, .req_ref_y, .req_cand_x, .req_cand_y,
      .rsp_valid, .rsp_near_distance, .rsp_raw_distance, .rsp_box_pass,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   function automatic logic [63:0] abs_diff(longint a, longint b);
      longint d;
      d = a - b;
      return (d < 0) ? 64'(-d) : 64'(d);
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r, bit_w;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   // |cos| of the mean latitude, Q1.COS_FRAC_BITS
   function automatic logic [63:0] mean_lat_cos(longint lat_sum, logic micro);
      logic [63:0] prod, x, x2, t, q;
      logic [31:0] ang;
      prod = 64'(lat_sum) * 64'(micro ? ANGLE_MUL_MODE1 : ANGLE_MUL_MODE0);
      ang = prod[55:24];
      if (ang[31]) ang = 32'd0 - ang;
      if (ang > 32'h4000_0000) ang = 32'h8000_0000 - ang;
      x = (64'(ang) * 64'(HALF_PI_Q30)) >> 30;
      x2 = (x * x) >> 30;
      t = 64'(ONE_Q30);
      for (int n = 7; n >= 1; n--) begin
         q = ((x2 * t) >> 30) / 64'((2 * n) * (2 * n - 1));
         t = (q > 64'(ONE_Q30)) ? 64'd0 : 64'(ONE_Q30) - q;
      end
      return (t + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
   endfunction

   function automatic logic [23:0] metres_between(coord_type rx, coord_type ry,
                                                   coord_type cx, coord_type cy);
      logic [63:0] scale, c, north, east, n2, s, m;
      scale = metric_micro ? 64'(SCALE_MODE1) : 64'(SCALE_MODE0);
      c = mean_lat_cos(longint'(ry) + longint'(cy), metric_micro);
      north = (abs_diff(ry, cy) * scale) >> 16;
      east = (((abs_diff(rx, cx) * c) >> (COS_FRAC_BITS - 8)) * scale) >> 24;
      if (north >= (64'd1 << 32) || east >= (64'd1 << 32)) return DIST_MAX;
      n2 = north * north;
      s = n2 + east * east;
      if (s < n2) return DIST_MAX;
      m = int_root(s) >> 8;
      return (m > 64'(DIST_MAX)) ? DIST_MAX : m[23:0];
   endfunction

   function automatic dist_result_type predict_pair(coord_type rx, coord_type ry,
                                                    coord_type cx, coord_type cy);
      dist_result_type r;
      logic [23:0] d;
      r.raw_dist = metres_between(rx, ry, cx, cy);
      r.in_box = abs_diff(rx, cx) < 64'(lim_box) && abs_diff(ry, cy) < 64'(lim_box);
      r.near_dist = 24'd0;
      if (r.in_box) begin
         d = (r.raw_dist == 0) ? 24'd1 : r.raw_dist;
         if (d < lim_distance) r.near_dist = d;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // result checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      dist_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result near=%0d raw=%0d box=%0d", $time,
                     rsp_near_distance, rsp_raw_distance, rsp_box_pass);
            errors++;
         end else begin
            e = pending_q.pop_front();
            n_checked++;
            if (rsp_near_distance !== e.near_dist) begin
               $display("%0t: near_distance expected %0d actual %0d", $time,
                        e.near_dist, rsp_near_distance);
               errors++;
            end
            if (rsp_raw_distance !== e.raw_dist) begin
               $display("%0t: raw_distance expected %0d actual %0d", $time,
                        e.raw_dist, rsp_raw_distance);
               errors++;
            end
            if (rsp_box_pass !== e.in_box) begin
               $display("%0t: box_pass expected %0d actual %0d", $time,
                        e.in_box, rsp_box_pass);
               errors++;
            end
            if (e.near_dist != 0) n_near++;
            if (!e.in_box) n_box_fail++;
            if (e.raw_dist == DIST_MAX) n_sat++;
         end
      end
   end

   // ------------------------------------------------------------------
   // shared tasks
   // ------------------------------------------------------------------
   task automatic write_reg(logic [1:0] idx, logic [27:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      case (idx)
         CSR_MAX_DISTANCE:   lim_distance = value[23:0];
         CSR_BOX_HALF_WIDTH: lim_box = value;
         CSR_UNIT_MODE:      metric_micro = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // send one point pair after a random gap; start stays high across a zero gap
   task automatic send_pair(coord_type rx, coord_type ry, coord_type cx, coord_type cy);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_ref_x = rx;
      req_ref_y = ry;
      req_cand_x = cx;
      req_cand_y = cy;
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_q.push_back(predict_pair(rx, ry, cx, cy));
   endtask

   // hold off until every expected result is in and the pipeline is empty
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic coord_type rand_coord();
      return coord_type'($urandom());
   endfunction

   // pairs close together, with random content, plus some noise
   task automatic send_random(int count, int spread);
      coord_type rx, ry;
      for (int i = 0; i < count; i++) begin
         rx = rand_coord();
         ry = rand_coord();
         if ($urandom_range(0, 9) < 8)
            send_pair(rx, ry, coord_type'(rx + $urandom_range(0, 2 * spread) - spread),
                      coord_type'(ry + $urandom_range(0, 2 * spread) - spread));
         else
            send_pair(rx, ry, rand_coord(), rand_coord());
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_pair('0, '0, '0, '0);
      send_pair(100, 200, 1000, 2000);
      send_pair(0, 0, 4095, -4095);
      send_pair(0, 0, 4096, 0);
      send_pair(0, 0, 0, -4096);
      drain();
   endtask

   task automatic test_extremes();
      coord_type cmin, cmax;
      cmin = coord_type'(1 << (COORD_BITS - 1));
      cmax = ~cmin;
      write_reg(CSR_MAX_DISTANCE, 28'hFFF_FFFF);
      write_reg(CSR_BOX_HALF_WIDTH, 28'hFFF_FFFF);
      send_pair(cmin, cmin, cmax, cmax);
      send_pair(cmax, cmax, cmin, cmin);
      send_pair(cmin, 0, cmax, 0);
      send_pair(0, cmax, 0, cmax);
      // poles in both units
      send_pair(0, 32400000, 5000000, 32400000);
      send_pair(0, -32400000, 5000000, -32400000);
      drain();
      write_reg(CSR_UNIT_MODE, 28'hFFF_FFF1);
      send_pair(0, 90000000, 5000000, 90000000);
      send_pair(0, -90000000, cmax, -90000000);
      send_pair(cmin, cmin, cmax, cmax);
      send_pair(7, 7, 7, 7);
      drain();
   endtask

   task automatic test_thresholds();
      dist_result_type e;
      write_reg(CSR_UNIT_MODE, 28'd0);
      write_reg(CSR_BOX_HALF_WIDTH, 28'd0);
      send_pair(5, 5, 5, 5);
      drain();
      write_reg(CSR_BOX_HALF_WIDTH, 28'd100000);
      write_reg(CSR_MAX_DISTANCE, 28'd0);
      send_pair(5, 5, 5, 5);
      send_pair(0, 0, 300, 0);
      drain();
      // distance exactly at the limit, then with the limit one above it
      e = predict_pair(0, 0, 0, 3000);
      write_reg(CSR_MAX_DISTANCE, 28'(e.raw_dist));
      send_pair(0, 0, 0, 3000);
      drain();
      write_reg(CSR_MAX_DISTANCE, 28'(e.raw_dist) + 28'd1);
      send_pair(0, 0, 0, 3000);
      send_pair(0, 0, 99999, 99999);
      send_pair(0, 0, 100000, 0);
      drain();
      // unused index must leave the registers alone
      write_reg(CSR_SPARE_INDEX, 28'hABC_DEF0);
      send_pair(0, 0, 0, 3000);
      drain();
   endtask

   task automatic test_random_sweep();
      write_reg(CSR_UNIT_MODE, 28'd0);
      write_reg(CSR_MAX_DISTANCE, 28'd1500);
      write_reg(CSR_BOX_HALF_WIDTH, 28'd4000);
      send_random(250, 5000);
      drain();
      write_reg(CSR_UNIT_MODE, 28'd1);
      write_reg(CSR_MAX_DISTANCE, 28'd400000);
      write_reg(CSR_BOX_HALF_WIDTH, 28'd3000000);
      send_random(250, 4000000);
      drain();
      write_reg(CSR_UNIT_MODE, 28'd0);
      write_reg(CSR_MAX_DISTANCE, 28'hFF_FFFF);
      write_reg(CSR_BOX_HALF_WIDTH, 28'hFFF_FFFF);
      send_random(300, 1 << 27);
      drain();
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_ref_x = '0;
      req_ref_y = '0;
      req_cand_x = '0;
      req_cand_y = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MAX_DISTANCE;
      csr_data = '0;
      lim_distance = 24'd1000;
      lim_box = 28'd4096;
      metric_micro = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_extremes();
      test_thresholds();
      test_random_sweep();

      $display("Checked %0d results: %0d near, %0d outside the box, %0d saturated,",
               n_checked, n_near, n_box_fail, n_sat);
      $display("over both units and register settings from zero to full scale.");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/npd_pkg.sv
rtl/npd_horner_cell.sv
rtl/npd_sqrt_cell.sv
rtl/near_point_distance_filter_unit.sv
rtl/npd_checker.sv
tb/tb_near_point_distance_filter_unit.sv
